@@ rtl/lstk_pkg.sv @@
// shared types and constants for the lru slot tracker
`default_nettype none

package lstk_pkg;

  localparam int unsigned NumSlots = 8;
  localparam int unsigned SlotW = $clog2(NumSlots);
  localparam int unsigned CntW = $clog2(NumSlots + 1);
  localparam int unsigned KindW = 3;
  localparam int unsigned IdW = 4;
  localparam int unsigned CmdW = 2;

  localparam int unsigned InFieldW = KindW + IdW;
  localparam int unsigned InDataW = ((InFieldW + 7) / 8) * 8;
  localparam int unsigned OutFieldW = SlotW + 1 + 1 + SlotW + 1 + SlotW + CntW + 1;
  localparam int unsigned OutDataW = ((OutFieldW + 7) / 8) * 8;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [KindW-1:0] kind_t;

  typedef enum logic [CmdW-1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_RAISE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/lstk_ctrl.sv @@
// controller state machine: request capture, lookup, commit and output handshake
`default_nettype none

module lstk_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  wire                 m_ready_i,
  output lstk_pkg::ctrl_cmd_t cmd_o
);
  import lstk_pkg::*;

  ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    out_valid_d = out_valid_q && !m_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        // commit once the output register is free
        if (!out_valid_q || m_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          s_ready_o    = 1'b1;
          if (s_valid_i) begin
            cmd_o.take = 1'b1;
            state_d    = ST_LOOKUP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/lstk_dp.sv @@
// datapath: slot table, recency list, target selection and list compaction
`default_nettype none

module lstk_dp (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  lstk_pkg::ctrl_cmd_t           cmd_i,
  input  wire [lstk_pkg::CmdW-1:0]      s_user_i,
  input  wire [lstk_pkg::InDataW-1:0]   s_data_i,
  input  wire                           cfg_we_i,
  input  wire [lstk_pkg::KindW-1:0]     cfg_wdata_i,
  output logic [lstk_pkg::OutDataW-1:0] result_o
);
  import lstk_pkg::*;

  // architectural state
  kind_t mik_q;
  logic [NumSlots-1:0] used_q, used_d;
  kind_t slot_kind_q [NumSlots];
  slot_t list_q [NumSlots];
  slot_t list_d [NumSlots];
  cnt_t cnt_q, cnt_d;

  // request register
  logic [CmdW-1:0] req_cmd_q;
  kind_t req_kind_q;
  logic [IdW-1:0] req_sid_q;

  // lookup stage register
  slot_t tgt_q, tgt_d;
  kind_t kind_q;
  logic rm_q, rm_d;
  logic app_q, app_d;
  logic set_used_q, set_used_d;
  logic clr_used_q, clr_used_d;
  logic hit_q, hit_d;
  logic ev_q, ev_d;
  logic err_q, err_d;
  slot_t res_q, res_d;

  logic [OutDataW-1:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mik_q <= KindW'(1);
    end else if (cfg_we_i) begin
      mik_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_cmd_q  <= s_user_i;
      req_kind_q <= s_data_i[KindW-1:0];
      req_sid_q  <= s_data_i[KindW +: IdW];
    end
  end

  // lookup: pick the target slot and the list actions
  logic [NumSlots-1:0] hit_vec;
  slot_t hit_idx, free_idx;
  logic any_hit, any_free;

  always_comb begin
    hit_vec  = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < NumSlots; i++) begin
      hit_vec[i] = used_q[i] && (slot_kind_q[i] == req_kind_q) && (req_kind_q != mik_q);
    end
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SlotW'(i);
      end
      if (!used_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
    any_hit  = |hit_vec;
    any_free = ~&used_q;
  end

  always_comb begin
    tgt_d      = '0;
    rm_d       = 1'b0;
    app_d      = 1'b0;
    set_used_d = 1'b0;
    clr_used_d = 1'b0;
    hit_d      = 1'b0;
    ev_d       = 1'b0;
    err_d      = 1'b0;
    res_d      = '0;
    unique case (req_cmd_q)
      CMD_OPEN: begin
        rm_d  = 1'b1;
        app_d = 1'b1;
        if (any_hit) begin
          tgt_d = hit_idx;
          hit_d = 1'b1;
        end else if (any_free) begin
          tgt_d      = free_idx;
          set_used_d = 1'b1;
        end else begin
          tgt_d      = (cnt_q != '0) ? list_q[0] : '0;
          set_used_d = 1'b1;
          ev_d       = 1'b1;
        end
        res_d = tgt_d;
      end
      CMD_CLOSE, CMD_RAISE: begin
        tgt_d = req_sid_q[SlotW-1:0];
        if (req_sid_q >= IdW'(NumSlots)) begin
          err_d = 1'b1;
        end else begin
          res_d = tgt_d;
          rm_d  = 1'b1;
          if (req_cmd_q == CMD_CLOSE) begin
            clr_used_d = 1'b1;
          end else begin
            app_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      tgt_q      <= tgt_d;
      kind_q     <= req_kind_q;
      rm_q       <= rm_d;
      app_q      <= app_d;
      set_used_q <= set_used_d;
      clr_used_q <= clr_used_d;
      hit_q      <= hit_d;
      ev_q       <= ev_d;
      err_q      <= err_d;
      res_q      <= res_d;
    end
  end

  // update: remove the target from the list, compact, append at the top
  logic [NumSlots-1:0] match;
  slot_t pos;
  logic found;
  cnt_t cnt_rm;
  logic app_ok;
  slot_t packed_list [NumSlots];
  slot_t top_slot;
  cnt_t top_idx;

  always_comb begin
    match = '0;
    pos   = '0;
    for (int i = 0; i < NumSlots; i++) begin
      match[i] = (list_q[i] == tgt_q) && (CntW'(i) < cnt_q);
    end
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = SlotW'(i);
      end
    end
    found  = rm_q && (|match);
    cnt_rm = cnt_q - CntW'(found);
    app_ok = app_q && (cnt_rm < CntW'(NumSlots));
    for (int i = 0; i < NumSlots - 1; i++) begin
      packed_list[i] = (found && (SlotW'(i) >= pos)) ? list_q[i+1] : list_q[i];
    end
    packed_list[NumSlots-1] = list_q[NumSlots-1];
    for (int i = 0; i < NumSlots; i++) begin
      list_d[i] = (app_ok && (CntW'(i) == cnt_rm)) ? tgt_q : packed_list[i];
    end
    cnt_d   = cnt_rm + CntW'(app_ok);
    top_idx = cnt_d - CntW'(1);
    if (cnt_d == '0) begin
      top_slot = '0;
    end else if (app_ok) begin
      top_slot = tgt_q;
    end else begin
      top_slot = packed_list[top_idx[SlotW-1:0]];
    end
    used_d = used_q;
    if (clr_used_q) begin
      used_d[tgt_q] = 1'b0;
    end
    if (set_used_q) begin
      used_d[tgt_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      used_q <= used_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < NumSlots; i++) begin
        list_q[i] <= list_d[i];
      end
      if (set_used_q) begin
        slot_kind_q[tgt_q] <= kind_q;
      end
      result_q <= {(OutDataW - OutFieldW)'(0), err_q, cnt_d, top_slot, (cnt_d != '0),
                   (ev_q ? tgt_q : slot_t'(0)), ev_q, hit_q, res_q};
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

@@ rtl/lru_slot_tracker_with_kind_lookup.sv @@
// top level of the lru slot tracker with lookup by kind
// a transfer in goes through lookup, then commit once the output register is free
// items are handled one at a time by the lookup/commit sequence on the slot table
// the next item is taken in the commit cycle while the result waits in the output register
// reset: slots free, recency list empty, multi-instance kind 1, no result pending
`default_nettype none

module lru_slot_tracker_with_kind_lookup (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // kind[2:0], slot_id[6:3], zero pad
  input  wire [lstk_pkg::InDataW-1:0]   s_axis_tdata,
  // command[1:0]
  input  wire [lstk_pkg::CmdW-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // result_slot[2:0], hit[3], evicted_valid[4], evicted_slot[7:5], top_valid[8],
  // top_slot[11:9], slot_count[15:12], error[16], zero pad
  output logic [lstk_pkg::OutDataW-1:0] m_axis_tdata,
  input  wire                           cfg_we_i,
  input  wire [lstk_pkg::KindW-1:0]     cfg_wdata_i
);
  import lstk_pkg::*;

  ctrl_cmd_t ctrl_cmd;

  lstk_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (ctrl_cmd)
  );

  lstk_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .s_user_i    (s_axis_tuser),
    .s_data_i    (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/lstk_checker.sv @@
// port-level assertions for the lru slot tracker, bound to the top level
`default_nettype none

module lstk_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           s_axis_tvalid,
  input wire                           s_axis_tready,
  input wire                           m_axis_tvalid,
  input wire                           m_axis_tready,
  input wire [lstk_pkg::OutDataW-1:0]  m_axis_tdata
);
  import lstk_pkg::*;

  // no result pending while in reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a transfer in is followed by the lookup cycle, which takes nothing
  a_lookup_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken during lookup");

  // a hit never evicts and never flags an error
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[4] && !m_axis_tdata[16])
    else $error("hit with eviction or error");

  // top valid follows the list count, which stays within the slot count
  a_top_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8] == (m_axis_tdata[15:12] != 4'd0)) &&
                      (m_axis_tdata[15:12] <= 4'(NumSlots)))
    else $error("top valid or slot count inconsistent");

endmodule

bind lru_slot_tracker_with_kind_lookup lstk_checker u_lstk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
